@@ hw/rtl/lpkv_pkg.sv @@
// Shared types, codes and the home-slot hash for the key/balance table.
package lpkv_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int KEY_CHARS_DEF   = 8;
    localparam int TOP_MAX_DEF     = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int HASH_P          = 37;
    localparam int HASH_W          = 20;

    localparam logic [2:0] OP_CREATE = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_QUERY  = 3'd2;
    localparam logic [2:0] OP_DELETE = 3'd3;
    localparam logic [2:0] OP_TOP    = 3'd4;

    localparam logic [1:0] RS_OK        = 2'd0;
    localparam logic [1:0] RS_NOT_FOUND = 2'd1;
    localparam logic [1:0] RS_FULL      = 2'd2;
    localparam logic [1:0] RS_PRESENT   = 2'd3;

    localparam logic [1:0] SLOT_EMPTY = 2'd0;
    localparam logic [1:0] SLOT_LIVE  = 2'd1;
    localparam logic [1:0] SLOT_TOMB  = 2'd2;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [63:0]        key_chars;
        logic [3:0]         key_length;
        logic signed [31:0] amount;
        logic [4:0]         top_count;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic signed [31:0] balance;
        logic [10:0]        account_count;
        logic               last;
    } rsp_t;

    typedef struct packed {
        logic [1:0]         state;
        logic [63:0]        key;
        logic [3:0]         len;
        logic signed [31:0] bal;
    } slot_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_MOD,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_EXEC,
        ST_TOP_SCAN,
        ST_EMIT
    } state_t;

    // Sum of (char+1)*(1+2*HASH_P*i) over the valid characters.
    function automatic logic [HASH_W-1:0] hash_sum(input logic [63:0] key,
                                                   input logic [3:0] len);
        logic [HASH_W-1:0] sum;
        logic [HASH_W-1:0] term;
        sum = '0;
        for (int i = 0; i < 8; i++)
        begin
            term = (HASH_W'(key[8*i +: 8]) + HASH_W'(1)) * HASH_W'(1 + 2 * HASH_P * i);
            if (4'(i) < len)
            begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

endpackage

@@ hw/rtl/lpkv_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
module lpkv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/linear_probing_key_value_table.sv @@
// Top level of the linear-probing key/balance table.
//
// Requests arrive on req/req_valid/req_stall and responses leave on
// rsp/rsp_valid/rsp_stall; a transfer happens on a clock edge with valid
// high and stall low. The block works on one request at a time and raises
// req_stall from acceptance until its last response sits in the output
// register, so the next request can be taken while that response waits.
// After acceptance, create, add, query and delete pass through the hash
// state, the reduction of the sum to a slot (reciprocal multiply, multiply
// back, final correction), a read set-up state, the probes on the table
// memory, an execute state and the output state that loads the response.
// Top-k gives one response per balance; each costs a full scan of the
// memory through the single read port, then the output state. Unknown
// opcodes and empty top-k go straight to the output state. After reset
// the block writes every slot empty, with req_stall high. A stalled
// response holds the output register and the internal sequencer waits
// before it produces the next response.
module linear_probing_key_value_table #(
    parameter int TABLE_DEPTH = lpkv_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_CHARS   = lpkv_pkg::KEY_CHARS_DEF,
    parameter int TOP_MAX     = lpkv_pkg::TOP_MAX_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  lpkv_pkg::req_t req,
    input  logic           req_valid,
    output logic           req_stall,
    output lpkv_pkg::rsp_t rsp,
    output logic           rsp_valid,
    input  logic           rsp_stall
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int HW     = lpkv_pkg::HASH_W;
    localparam int ROW_W  = $bits(lpkv_pkg::slot_t);
    // floor(2^(HW+ADDR_W) / depth); the quotient estimate it gives is exact
    // or one too small for any HW-bit sum.
    localparam logic [HW:0] RECIP = (HW+1)'((64'd1 << (HW + ADDR_W)) / 64'(TABLE_DEPTH));

    lpkv_pkg::state_t state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [2:0] op_reg, op_next;
    logic [63:0] key_reg, key_next;
    logic [3:0] len_reg, len_next;
    logic signed [31:0] amt_reg, amt_next;
    logic [HW-1:0] rem_reg, rem_next;
    logic [HW-1:0] quo_reg, quo_next;
    logic [4:0] step_reg, step_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [ADDR_W:0] probes_reg, probes_next;
    logic free_v_reg, free_v_next;
    logic [ADDR_W-1:0] free_reg, free_next;
    logic hit_reg, hit_next;
    logic [ADDR_W-1:0] hit_idx_reg, hit_idx_next;
    logic signed [31:0] hit_bal_reg, hit_bal_next;
    logic [CNT_W-1:0] live_reg, live_next;
    lpkv_pkg::rsp_t res_reg, res_next;
    lpkv_pkg::rsp_t rsp_reg, rsp_next;
    logic rsp_valid_reg, rsp_valid_next;
    logic [4:0] left_reg, left_next;
    logic [ADDR_W:0] issue_reg, issue_next;
    logic rdv_reg, rdv_next;
    logic [ADDR_W-1:0] rdidx_reg, rdidx_next;
    logic best_v_reg, best_v_next;
    logic [ADDR_W-1:0] best_reg, best_next;
    logic signed [31:0] best_bal_reg, best_bal_next;
    logic prev_v_reg, prev_v_next;
    logic [ADDR_W-1:0] prev_idx_reg, prev_idx_next;
    logic signed [31:0] prev_bal_reg, prev_bal_next;

    logic ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    lpkv_pkg::slot_t ram_wrow, ram_rrow;
    logic [ROW_W-1:0] ram_rdata;

    logic req_acc, rsp_free;
    logic [3:0] len_c;
    logic [63:0] key_c;
    logic [31:0] cnt_c;
    logic [2*HW:0] prod_c;
    logic signed [32:0] sum_c;
    logic signed [31:0] sat_c;
    logic eligible_c;
    logic [ADDR_W-1:0] idx_inc;

    lpkv_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TABLE_DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wrow),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_rrow  = lpkv_pkg::slot_t'(ram_rdata);
    assign req_stall = (state_reg != lpkv_pkg::ST_IDLE);
    assign req_acc   = req_valid && !req_stall;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lpkv_pkg::ST_CLEAR;
            clr_reg       <= '0;
            live_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            rdv_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            live_reg      <= live_next;
            rsp_valid_reg <= rsp_valid_next;
            rdv_reg       <= rdv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        len_reg      <= len_next;
        amt_reg      <= amt_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        step_reg     <= step_next;
        idx_reg      <= idx_next;
        probes_reg   <= probes_next;
        free_v_reg   <= free_v_next;
        free_reg     <= free_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        hit_bal_reg  <= hit_bal_next;
        res_reg      <= res_next;
        rsp_reg      <= rsp_next;
        left_reg     <= left_next;
        issue_reg    <= issue_next;
        rdidx_reg    <= rdidx_next;
        best_v_reg   <= best_v_next;
        best_reg     <= best_next;
        best_bal_reg <= best_bal_next;
        prev_v_reg   <= prev_v_next;
        prev_idx_reg <= prev_idx_next;
        prev_bal_reg <= prev_bal_next;
    end

    always_comb
    begin
        // Keys longer than KEY_CHARS are cut, and bytes past the length are dropped.
        len_c = (req.key_length > 4'(KEY_CHARS)) ? 4'(KEY_CHARS) : req.key_length;
        for (int i = 0; i < 8; i++)
        begin
            key_c[8*i +: 8] = (4'(i) < len_c) ? req.key_chars[8*i +: 8] : 8'd0;
        end

        cnt_c = 32'(req.top_count);
        if (cnt_c > 32'(live_reg))
        begin
            cnt_c = 32'(live_reg);
        end
        if (cnt_c > 32'(TOP_MAX))
        begin
            cnt_c = 32'(TOP_MAX);
        end
        if (cnt_c > 32'(lpkv_pkg::MAX_RESULTS))
        begin
            cnt_c = 32'(lpkv_pkg::MAX_RESULTS);
        end

        prod_c  = (2*HW+1)'(rem_reg) * (2*HW+1)'(RECIP);
        sum_c   = 33'(hit_bal_reg) + 33'(amt_reg);
        if (sum_c > 33'sd2147483647)
        begin
            sat_c = 32'sh7FFFFFFF;
        end
        else if (sum_c < -33'sd2147483648)
        begin
            sat_c = 32'sh80000000;
        end
        else
        begin
            sat_c = sum_c[31:0];
        end
        idx_inc = (idx_reg == ADDR_W'(TABLE_DEPTH - 1)) ? '0 : idx_reg + 1'b1;

        // Top-k walks down the order (balance descending, then slot ascending).
        eligible_c = !prev_v_reg
                  || (ram_rrow.bal < prev_bal_reg)
                  || ((ram_rrow.bal == prev_bal_reg) && (rdidx_reg > prev_idx_reg));

        state_next     = state_reg;
        clr_next       = clr_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        len_next       = len_reg;
        amt_next       = amt_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        idx_next       = idx_reg;
        probes_next    = probes_reg;
        free_v_next    = free_v_reg;
        free_next      = free_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_bal_next   = hit_bal_reg;
        live_next      = live_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        left_next      = left_reg;
        issue_next     = issue_reg;
        rdv_next       = 1'b0;
        rdidx_next     = rdidx_reg;
        best_v_next    = best_v_reg;
        best_next      = best_reg;
        best_bal_next  = best_bal_reg;
        prev_v_next    = prev_v_reg;
        prev_idx_next  = prev_idx_reg;
        prev_bal_next  = prev_bal_reg;

        ram_we    = 1'b0;
        ram_waddr = clr_reg;
        ram_wrow  = '0;
        ram_raddr = idx_reg;

        case (state_reg)
            lpkv_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wrow  = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(TABLE_DEPTH - 1))
                begin
                    state_next = lpkv_pkg::ST_IDLE;
                end
            end

            lpkv_pkg::ST_IDLE:
            begin
                if (req_acc)
                begin
                    op_next  = req.opcode;
                    key_next = key_c;
                    len_next = len_c;
                    amt_next = req.amount;
                    res_next = '{status: lpkv_pkg::RS_NOT_FOUND, found: 1'b0,
                                 balance: -32'sd1, account_count: 11'(live_reg),
                                 last: 1'b1};
                    if (req.opcode == lpkv_pkg::OP_TOP)
                    begin
                        if (cnt_c == 32'd0)
                        begin
                            state_next = lpkv_pkg::ST_EMIT;
                        end
                        else
                        begin
                            left_next   = cnt_c[4:0];
                            prev_v_next = 1'b0;
                            issue_next  = '0;
                            best_v_next = 1'b0;
                            state_next  = lpkv_pkg::ST_TOP_SCAN;
                        end
                    end
                    else if (req.opcode > lpkv_pkg::OP_TOP)
                    begin
                        state_next = lpkv_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = lpkv_pkg::ST_HASH;
                    end
                end
            end

            lpkv_pkg::ST_HASH:
            begin
                rem_next   = lpkv_pkg::hash_sum(key_reg, len_reg);
                step_next  = 5'd2;
                state_next = lpkv_pkg::ST_MOD;
            end

            lpkv_pkg::ST_MOD:
            begin
                // Sum modulo depth in three steps: estimate the quotient with
                // the reciprocal, subtract quotient times depth, then take off
                // one more depth if the estimate was one short.
                step_next = step_reg - 1'b1;
                if (step_reg == 5'd2)
                begin
                    quo_next = HW'(prod_c >> (HW + ADDR_W));
                end
                else if (step_reg == 5'd1)
                begin
                    rem_next = rem_reg - HW'(quo_reg * HW'(TABLE_DEPTH));
                end
                else
                begin
                    idx_next    = (rem_reg >= HW'(TABLE_DEPTH))
                                  ? ADDR_W'(rem_reg - HW'(TABLE_DEPTH))
                                  : ADDR_W'(rem_reg);
                    probes_next = '0;
                    free_v_next = 1'b0;
                    hit_next    = 1'b0;
                    state_next  = lpkv_pkg::ST_PROBE_RD;
                end
            end

            lpkv_pkg::ST_PROBE_RD:
            begin
                ram_raddr  = idx_reg;
                state_next = lpkv_pkg::ST_PROBE_CHK;
            end

            lpkv_pkg::ST_PROBE_CHK:
            begin
                if (ram_rrow.state == lpkv_pkg::SLOT_EMPTY)
                begin
                    if (!free_v_reg)
                    begin
                        free_v_next = 1'b1;
                        free_next   = idx_reg;
                    end
                    state_next = lpkv_pkg::ST_EXEC;
                end
                else if ((ram_rrow.state == lpkv_pkg::SLOT_LIVE)
                         && (ram_rrow.len == len_reg) && (ram_rrow.key == key_reg))
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = idx_reg;
                    hit_bal_next = ram_rrow.bal;
                    state_next   = lpkv_pkg::ST_EXEC;
                end
                else
                begin
                    if ((ram_rrow.state == lpkv_pkg::SLOT_TOMB) && !free_v_reg)
                    begin
                        free_v_next = 1'b1;
                        free_next   = idx_reg;
                    end
                    if (probes_reg == (ADDR_W + 1)'(TABLE_DEPTH - 1))
                    begin
                        state_next = lpkv_pkg::ST_EXEC;
                    end
                    else
                    begin
                        // Issue the next probe straight away: one slot per cycle.
                        idx_next    = idx_inc;
                        probes_next = probes_reg + 1'b1;
                        ram_raddr   = idx_inc;
                    end
                end
            end

            lpkv_pkg::ST_EXEC:
            begin
                res_next.last  = 1'b1;
                res_next.found = hit_reg;
                if (hit_reg)
                begin
                    res_next.status  = lpkv_pkg::RS_OK;
                    res_next.balance = hit_bal_reg;
                    case (op_reg)
                        lpkv_pkg::OP_CREATE:
                        begin
                            res_next.status = lpkv_pkg::RS_PRESENT;
                        end
                        lpkv_pkg::OP_ADD:
                        begin
                            ram_we           = 1'b1;
                            ram_waddr        = hit_idx_reg;
                            ram_wrow         = '{state: lpkv_pkg::SLOT_LIVE, key: key_reg,
                                                 len: len_reg, bal: sat_c};
                            res_next.balance = sat_c;
                        end
                        lpkv_pkg::OP_DELETE:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = hit_idx_reg;
                            ram_wrow  = '{state: lpkv_pkg::SLOT_TOMB, key: key_reg,
                                          len: len_reg, bal: 32'sd0};
                            if (live_reg != '0)
                            begin
                                live_next = live_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else
                begin
                    res_next.status  = lpkv_pkg::RS_NOT_FOUND;
                    res_next.balance = -32'sd1;
                    if ((op_reg == lpkv_pkg::OP_CREATE) || (op_reg == lpkv_pkg::OP_ADD))
                    begin
                        if ((live_reg >= CNT_W'(TABLE_DEPTH)) || !free_v_reg)
                        begin
                            res_next.status = lpkv_pkg::RS_FULL;
                        end
                        else
                        begin
                            ram_we           = 1'b1;
                            ram_waddr        = free_reg;
                            ram_wrow         = '{state: lpkv_pkg::SLOT_LIVE, key: key_reg,
                                                 len: len_reg, bal: amt_reg};
                            live_next        = live_reg + 1'b1;
                            res_next.status  = lpkv_pkg::RS_OK;
                            res_next.balance = amt_reg;
                        end
                    end
                end
                res_next.account_count = 11'(live_next);
                state_next = lpkv_pkg::ST_EMIT;
            end

            lpkv_pkg::ST_TOP_SCAN:
            begin
                if (issue_reg < (ADDR_W + 1)'(TABLE_DEPTH))
                begin
                    ram_raddr  = issue_reg[ADDR_W-1:0];
                    issue_next = issue_reg + 1'b1;
                    rdv_next   = 1'b1;
                    rdidx_next = issue_reg[ADDR_W-1:0];
                end
                if (rdv_reg)
                begin
                    if ((ram_rrow.state == lpkv_pkg::SLOT_LIVE) && eligible_c
                        && (!best_v_reg || (ram_rrow.bal > best_bal_reg)))
                    begin
                        best_v_next   = 1'b1;
                        best_next     = rdidx_reg;
                        best_bal_next = ram_rrow.bal;
                    end
                end
                else if (issue_reg == (ADDR_W + 1)'(TABLE_DEPTH))
                begin
                    res_next      = '{status: lpkv_pkg::RS_OK, found: 1'b1,
                                      balance: best_bal_reg,
                                      account_count: 11'(live_reg),
                                      last: (left_reg == 5'd1)};
                    prev_v_next   = 1'b1;
                    prev_idx_next = best_reg;
                    prev_bal_next = best_bal_reg;
                    left_next     = left_reg - 1'b1;
                    state_next    = lpkv_pkg::ST_EMIT;
                end
            end

            lpkv_pkg::ST_EMIT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    if (res_reg.last)
                    begin
                        state_next = lpkv_pkg::ST_IDLE;
                    end
                    else
                    begin
                        issue_next  = '0;
                        best_v_next = 1'b0;
                        state_next  = lpkv_pkg::ST_TOP_SCAN;
                    end
                end
            end

            default:
            begin
                state_next = lpkv_pkg::ST_IDLE;
            end
        endcase
    end

    a_live_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= CNT_W'(TABLE_DEPTH))
        else $error("live count exceeds table depth");

    a_scan_read_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lpkv_pkg::ST_TOP_SCAN) |-> !ram_we)
        else $error("table written during top-k scan");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> (state_reg != lpkv_pkg::ST_IDLE))
        else $error("sequencer idle right after accepting a request");

    a_emit_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_stall && (state_reg == lpkv_pkg::ST_EMIT))
            |=> (state_reg == lpkv_pkg::ST_EMIT))
        else $error("response overwrote a stalled response");

endmodule
